// ----- src/lstxy_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lstxy_pkg;

   localparam int unsigned MAX_POINTS_DEF    = 1024;
   localparam int unsigned FIRST_RANGE_TOKEN = 26;
   localparam int unsigned CORDIC_STEPS      = 18;
   localparam int unsigned STEP_TOKEN        = 24;
   localparam int unsigned COUNT_TOKEN       = 25;
   localparam int unsigned FULL_TURN         = 3600000;
   localparam int unsigned QUARTER_TURN      = 900000;
   localparam int unsigned REDUCE_TOP        = 10;
   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

   localparam logic [7:0] CHAR_STX   = 8'h02;
   localparam logic [7:0] CHAR_ETX   = 8'h03;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [11:0] TOKEN_SAT = 12'hFFF;

   localparam logic [0:0] CSR_EXP_TOKENS = 1'b0;
   localparam logic [0:0] CSR_EXP_POINTS = 1'b1;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_TOKENS     = 2'd1,
      ST_POINTS     = 2'd2,
      ST_BAD_DATA   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_REDUCE,
      S_ANGLE,
      S_QUAD,
      S_ROTATE,
      S_MULX,
      S_MULY,
      S_ROUND,
      S_POINT,
      S_STATUS
   } back_state_type;

   typedef struct packed {
      logic        has_point;
      logic        has_status;
      logic [11:0] index;
      logic [15:0] range;
      logic        bad;
      status_type  status;
      logic [31:0] step;
   } cmd_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] k);
      logic [31:0] v;
      case (k)
         5'd0:  v = 32'd115200000;
         5'd1:  v = 32'd68006531;
         5'd2:  v = 32'd35932783;
         5'd3:  v = 32'd18240042;
         5'd4:  v = 32'd9155416;
         5'd5:  v = 32'd4582171;
         5'd6:  v = 32'd2291645;
         5'd7:  v = 32'd1145892;
         5'd8:  v = 32'd572955;
         5'd9:  v = 32'd286479;
         5'd10: v = 32'd143239;
         5'd11: v = 32'd71620;
         5'd12: v = 32'd35810;
         5'd13: v = 32'd17905;
         5'd14: v = 32'd8952;
         5'd15: v = 32'd4476;
         5'd16: v = 32'd2238;
         5'd17: v = 32'd1119;
         5'd18: v = 32'd560;
         5'd19: v = 32'd280;
         5'd20: v = 32'd140;
         5'd21: v = 32'd70;
         5'd22: v = 32'd35;
         5'd23: v = 32'd17;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [16:0] limit17(input logic signed [19:0] v);
      logic signed [16:0] r;
      if (v > 20'sd65535) r = 17'sd65535;
      else if (v < -20'sd65535) r = -17'sd65535;
      else r = v[16:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- src/lstxy_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lstxy_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire lstxy_pkg::cmd_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output lstxy_pkg::cmd_type     head_data
);
   lstxy_pkg::cmd_type mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end
endmodule
`default_nettype wire

// ----- src/lstxy_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lstxy_front #(
   parameter int unsigned MAX_POINTS = lstxy_pkg::MAX_POINTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              byte_accept,
   input  wire logic [7:0]        data_byte,
   input  wire logic [11:0]       exp_tokens,
   input  wire logic [10:0]       exp_points,
   output logic                   push,
   output lstxy_pkg::cmd_type     push_data
);
   logic        in_frame_ff, in_frame_in;
   logic [11:0] tok_ff, tok_in;
   logic [31:0] acc_ff, acc_in;
   logic        bad_ff, bad_in;
   logic [31:0] step_ff, step_in;
   logic [31:0] ann_ff, ann_in;
   lstxy_pkg::status_type fs_ff, fs_in;

   logic        is_hex;
   logic [3:0]  digit;
   logic [11:0] idx;
   logic        emit_pt, emit_st, rbad;
   lstxy_pkg::status_type st;

   always_comb begin
      is_hex = 1'b1;
      digit  = 4'd0;
      if (data_byte >= 8'h30 && data_byte <= 8'h39) digit = 4'(data_byte - 8'h30);
      else if (data_byte >= 8'h61 && data_byte <= 8'h66) digit = 4'(data_byte - 8'h57);
      else if (data_byte >= 8'h41 && data_byte <= 8'h46) digit = 4'(data_byte - 8'h37);
      else is_hex = 1'b0;
   end

   always_comb begin
      in_frame_in = in_frame_ff;
      tok_in  = tok_ff;
      acc_in  = acc_ff;
      bad_in  = bad_ff;
      step_in = step_ff;
      ann_in  = ann_ff;
      fs_in   = fs_ff;
      emit_pt = 1'b0;
      emit_st = 1'b0;
      rbad    = 1'b0;
      st      = lstxy_pkg::ST_OK;
      idx     = tok_ff - 12'(lstxy_pkg::FIRST_RANGE_TOKEN);
      if (byte_accept) begin
         if (data_byte == lstxy_pkg::CHAR_STX) begin
            in_frame_in = 1'b1;
            tok_in = '0; acc_in = '0; bad_in = 1'b0;
            step_in = '0; ann_in = '0; fs_in = lstxy_pkg::ST_OK;
         end else if (in_frame_ff) begin
            if (data_byte == lstxy_pkg::CHAR_SPACE || data_byte == lstxy_pkg::CHAR_ETX) begin
               // close the current token
               if (tok_ff == 12'(lstxy_pkg::STEP_TOKEN)) begin
                  step_in = acc_ff;
                  if (bad_ff) fs_in = lstxy_pkg::ST_BAD_DATA;
               end
               if (tok_ff == 12'(lstxy_pkg::COUNT_TOKEN)) begin
                  ann_in = acc_ff;
                  if (bad_ff) fs_in = lstxy_pkg::ST_BAD_DATA;
               end
               if (tok_ff >= 12'(lstxy_pkg::FIRST_RANGE_TOKEN) && tok_ff != lstxy_pkg::TOKEN_SAT
                   && {20'd0, idx} < ann_in && 13'(idx) < 13'(MAX_POINTS)) begin
                  emit_pt = 1'b1;
                  rbad = bad_ff || (acc_ff[31:16] != 16'd0);
                  if (rbad) fs_in = lstxy_pkg::ST_BAD_DATA;
               end
               if (tok_ff != lstxy_pkg::TOKEN_SAT) tok_in = tok_ff + 12'd1;
               acc_in = '0;
               bad_in = 1'b0;
               if (data_byte == lstxy_pkg::CHAR_ETX) begin
                  emit_st = 1'b1;
                  if (tok_in == lstxy_pkg::TOKEN_SAT || tok_in != exp_tokens)
                     st = lstxy_pkg::ST_TOKENS;
                  else if (ann_in != {21'd0, exp_points})
                     st = lstxy_pkg::ST_POINTS;
                  else
                     st = fs_in;
                  in_frame_in = 1'b0;
                  tok_in = '0; step_in = '0; ann_in = '0; fs_in = lstxy_pkg::ST_OK;
               end
            end else if (!is_hex) begin
               bad_in = 1'b1;
            end else begin
               if (acc_ff[31:28] != 4'd0) bad_in = 1'b1;
               acc_in = {acc_ff[27:0], digit};
            end
         end
      end
   end

   assign push = emit_pt || emit_st;

   always_comb begin
      push_data.has_point  = emit_pt;
      push_data.has_status = emit_st;
      push_data.index      = idx;
      push_data.range      = rbad ? 16'd0 : acc_ff[15:0];
      push_data.bad        = rbad;
      push_data.status     = st;
      // the angle uses the step in force after this token
      push_data.step       = (tok_ff == 12'(lstxy_pkg::STEP_TOKEN)) ? acc_ff : step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         tok_ff  <= '0;
         acc_ff  <= '0;
         bad_ff  <= 1'b0;
         step_ff <= '0;
         ann_ff  <= '0;
         fs_ff   <= lstxy_pkg::ST_OK;
      end else begin
         in_frame_ff <= in_frame_in;
         tok_ff  <= tok_in;
         acc_ff  <= acc_in;
         bad_ff  <= bad_in;
         step_ff <= step_in;
         ann_ff  <= ann_in;
         fs_ff   <= fs_in;
      end
   end
endmodule
`default_nettype wire

// ----- src/lstxy_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lstxy_back #(
   parameter int unsigned MAX_POINTS = lstxy_pkg::MAX_POINTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire lstxy_pkg::cmd_type head_data,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_kind,
   output logic [9:0]             rsp_point_index,
   output logic [15:0]            rsp_range_value,
   output logic signed [16:0]     rsp_x_coord,
   output logic signed [16:0]     rsp_y_coord,
   output logic [1:0]             rsp_status_code,
   output logic                   rsp_last_flag
);
   localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam logic [21:0] F22 = 22'(lstxy_pkg::FULL_TURN);
   localparam logic [21:0] Q1  = 22'(lstxy_pkg::QUARTER_TURN);
   localparam logic [21:0] Q2  = 22'(2 * lstxy_pkg::QUARTER_TURN);
   localparam logic [21:0] Q3  = 22'(3 * lstxy_pkg::QUARTER_TURN);

   lstxy_pkg::back_state_type state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] sr_ff, sr_in;
   logic [21:0] a_ff, a_in;
   logic [11:0] idx_ff, idx_in;
   logic [1:0]  q_ff, q_in;
   logic signed [32:0] x_ff, x_in, y_ff, y_in;
   logic signed [31:0] z_ff, z_in;
   logic signed [49:0] px_ff, px_in, py_ff, py_in;
   logic signed [16:0] ox_ff, ox_in, oy_ff, oy_in;

   logic [31:0] thr;
   logic [22:0] dbl, sum;
   logic [21:0] rest;
   logic signed [49:0] rx_full, ry_full;
   logic signed [19:0] cx, sy;
   logic signed [32:0] dx, dy;
   logic signed [16:0] rng_s;

   assign rng_s = $signed({1'b0, head_data.range});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lstxy_pkg::S_IDLE:
            if (head_valid) begin
               if (!head_data.has_point) state_in = lstxy_pkg::S_STATUS;
               else if (head_data.bad)   state_in = lstxy_pkg::S_POINT;
               else                      state_in = lstxy_pkg::S_REDUCE;
            end
         lstxy_pkg::S_REDUCE: if (cnt_ff == 5'd0) state_in = lstxy_pkg::S_ANGLE;
         lstxy_pkg::S_ANGLE:  if (cnt_ff == 5'd0) state_in = lstxy_pkg::S_QUAD;
         lstxy_pkg::S_QUAD:   state_in = lstxy_pkg::S_ROTATE;
         lstxy_pkg::S_ROTATE:
            if (cnt_ff == 5'(lstxy_pkg::CORDIC_STEPS - 1)) state_in = lstxy_pkg::S_MULX;
         lstxy_pkg::S_MULX:   state_in = lstxy_pkg::S_MULY;
         lstxy_pkg::S_MULY:   state_in = lstxy_pkg::S_ROUND;
         lstxy_pkg::S_ROUND:  state_in = lstxy_pkg::S_POINT;
         lstxy_pkg::S_POINT:
            if (rsp_ready)
               state_in = head_data.has_status ? lstxy_pkg::S_STATUS : lstxy_pkg::S_IDLE;
         lstxy_pkg::S_STATUS: if (rsp_ready) state_in = lstxy_pkg::S_IDLE;
         default: state_in = lstxy_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      rsp_valid       = 1'b0;
      rsp_kind        = 1'b0;
      rsp_last_flag   = 1'b0;
      rsp_point_index = 10'd0;
      rsp_range_value = 16'd0;
      rsp_x_coord     = 17'sd0;
      rsp_y_coord     = 17'sd0;
      rsp_status_code = 2'd0;
      pop             = 1'b0;
      case (state_ff)
         lstxy_pkg::S_POINT: begin
            rsp_valid       = 1'b1;
            rsp_point_index = head_data.index[9:0];
            rsp_range_value = head_data.range;
            rsp_x_coord     = ox_ff;
            rsp_y_coord     = oy_ff;
            pop             = rsp_ready && !head_data.has_status;
         end
         lstxy_pkg::S_STATUS: begin
            rsp_valid       = 1'b1;
            rsp_kind        = 1'b1;
            rsp_last_flag   = 1'b1;
            rsp_status_code = head_data.status;
            pop             = rsp_ready;
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      cnt_in = cnt_ff; sr_in = sr_ff; a_in = a_ff; idx_in = idx_ff; q_in = q_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; px_in = px_ff; py_in = py_ff;
      ox_in = ox_ff; oy_in = oy_ff;
      thr  = 32'(64'(lstxy_pkg::FULL_TURN) << cnt_ff);
      dbl  = {a_ff, 1'b0};
      if (dbl >= {1'b0, F22}) dbl = dbl - {1'b0, F22};
      sum  = dbl + ((idx_ff[IDX_W-1]) ? {1'b0, sr_ff[21:0]} : 23'd0);
      if (sum >= {1'b0, F22}) sum = sum - {1'b0, F22};
      rest = a_ff;
      dx   = x_ff;
      dy   = y_ff;
      rx_full = (px_ff + 50'sd536870912) >>> 30;
      ry_full = (py_ff + 50'sd536870912) >>> 30;
      cx = rx_full[19:0];
      sy = ry_full[19:0];
      case (state_ff)
         lstxy_pkg::S_IDLE:
            if (head_valid && head_data.has_point) begin
               ox_in  = 17'sd0;
               oy_in  = 17'sd0;
               sr_in  = head_data.step;
               cnt_in = 5'(lstxy_pkg::REDUCE_TOP);
            end
         lstxy_pkg::S_REDUCE: begin
            // restoring reduction of the step modulo a full turn
            if (sr_ff >= thr) sr_in = sr_ff - thr;
            if (cnt_ff == 5'd0) begin
               cnt_in = 5'(IDX_W - 1);
               a_in   = 22'd0;
               idx_in = head_data.index;
            end else cnt_in = cnt_ff - 5'd1;
         end
         lstxy_pkg::S_ANGLE: begin
            a_in   = sum[21:0];
            idx_in = idx_ff << 1;
            if (cnt_ff != 5'd0) cnt_in = cnt_ff - 5'd1;
         end
         lstxy_pkg::S_QUAD: begin
            if (a_ff >= Q3)      begin q_in = 2'd3; rest = a_ff - Q3; end
            else if (a_ff >= Q2) begin q_in = 2'd2; rest = a_ff - Q2; end
            else if (a_ff >= Q1) begin q_in = 2'd1; rest = a_ff - Q1; end
            else                 begin q_in = 2'd0; rest = a_ff; end
            z_in   = $signed({2'b00, rest, 8'd0});
            x_in   = lstxy_pkg::CORDIC_GAIN;
            y_in   = 33'sd0;
            cnt_in = 5'd0;
         end
         lstxy_pkg::S_ROTATE: begin
            dx = y_ff >>> cnt_ff;
            dy = x_ff >>> cnt_ff;
            if (z_ff >= 32'sd0) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - $signed(lstxy_pkg::atan_entry(cnt_ff));
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + $signed(lstxy_pkg::atan_entry(cnt_ff));
            end
            cnt_in = cnt_ff + 5'd1;
         end
         lstxy_pkg::S_MULX: px_in = rng_s * x_ff;
         lstxy_pkg::S_MULY: py_in = rng_s * y_ff;
         lstxy_pkg::S_ROUND:
            case (q_ff)
               2'd0: begin ox_in = lstxy_pkg::limit17(cx);  oy_in = lstxy_pkg::limit17(sy);  end
               2'd1: begin ox_in = lstxy_pkg::limit17(-sy); oy_in = lstxy_pkg::limit17(cx);  end
               2'd2: begin ox_in = lstxy_pkg::limit17(-cx); oy_in = lstxy_pkg::limit17(-sy); end
               default: begin
                  ox_in = lstxy_pkg::limit17(sy);
                  oy_in = lstxy_pkg::limit17(-cx);
               end
            endcase
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= lstxy_pkg::S_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in; sr_ff <= sr_in; a_ff <= a_in; idx_ff <= idx_in; q_ff <= q_in;
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; px_ff <= px_in; py_ff <= py_in;
      ox_ff <= ox_in; oy_ff <= oy_in;
   end
endmodule
`default_nettype wire

// ----- src/lidar_scan_telegram_to_xy_core.sv -----
// Bytes are taken one per cycle while the two-entry command queue has room.
// A well-formed range point leaves after its closing byte through step reduction, an
// angle build over the index bits, quadrant folding, 18 CORDIC iterations, the x and
// y multiplies and rounding; the shared CORDIC works on one point at a time.
// Synchronous active-high reset clears the parser, queue and sequencer and loads
// expected_tokens = 393, expected_points = 361.
`timescale 1ns / 1ps
`default_nettype none
module lidar_scan_telegram_to_xy_core #(
   parameter int unsigned MAX_POINTS = lstxy_pkg::MAX_POINTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_data_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_kind,
   output logic [9:0]             rsp_point_index,
   output logic [15:0]            rsp_range_value,
   output logic signed [16:0]     rsp_x_coord,
   output logic signed [16:0]     rsp_y_coord,
   output logic [1:0]             rsp_status_code,
   output logic                   rsp_last_flag,
   input  wire logic              csr_write_enable,
   input  wire logic [0:0]        csr_index,
   input  wire logic [11:0]       csr_write_data
);
   logic [11:0] exp_tokens_ff, exp_tokens_in;
   logic [10:0] exp_points_ff, exp_points_in;
   logic        full, push, pop, head_valid;
   lstxy_pkg::cmd_type push_data, head_data;

   assign req_ready = !full;

   always_comb begin
      exp_tokens_in = exp_tokens_ff;
      exp_points_in = exp_points_ff;
      if (csr_write_enable) begin
         case (csr_index)
            lstxy_pkg::CSR_EXP_TOKENS: exp_tokens_in = csr_write_data;
            lstxy_pkg::CSR_EXP_POINTS: exp_points_in = csr_write_data[10:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_tokens_ff <= 12'd393;
         exp_points_ff <= 11'd361;
      end else begin
         exp_tokens_ff <= exp_tokens_in;
         exp_points_ff <= exp_points_in;
      end
   end

   lstxy_front #(.MAX_POINTS(MAX_POINTS)) u_front (
      .clock(clock), .reset(reset),
      .byte_accept(req_valid && req_ready), .data_byte(req_data_byte),
      .exp_tokens(exp_tokens_ff), .exp_points(exp_points_ff),
      .push(push), .push_data(push_data)
   );

   lstxy_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push(push), .push_data(push_data), .full(full),
      .pop(pop), .head_valid(head_valid), .head_data(head_data)
   );

   lstxy_back #(.MAX_POINTS(MAX_POINTS)) u_back (
      .clock(clock), .reset(reset),
      .head_valid(head_valid), .head_data(head_data), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_point_index(rsp_point_index), .rsp_range_value(rsp_range_value),
      .rsp_x_coord(rsp_x_coord), .rsp_y_coord(rsp_y_coord),
      .rsp_status_code(rsp_status_code), .rsp_last_flag(rsp_last_flag)
   );
endmodule
`default_nettype wire
